[rtl/beacon_element_parser_macros.svh]
// Assertion macros for the beacon element parser.
// Included by files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef BEACON_ELEMENT_PARSER_MACROS_SVH
`define BEACON_ELEMENT_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen at a clock edge.
`define BEP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/bep_pkg.sv]
// Shared types, constants and helper functions of the beacon element parser.
// No dependencies; bep_front, bep_queue, bep_back and the top level refer to it by scoped names.
package bep_pkg;

    localparam int SSID_MAX_DEF = 32;
    localparam int BODY_START   = 36;

    // Offsets inside the fixed part of the frame.
    localparam int OFF_W = $clog2(BODY_START + 1);
    localparam logic [OFF_W-1:0] OFF_INT_LO = OFF_W'(32);
    localparam logic [OFF_W-1:0] OFF_INT_HI = OFF_W'(33);
    localparam logic [OFF_W-1:0] OFF_CAP_LO = OFF_W'(34);
    localparam logic [OFF_W-1:0] OFF_MIN_OK = OFF_W'(BODY_START - 1);
    localparam logic [OFF_W-1:0] OFF_BODY   = OFF_W'(BODY_START);
    localparam int PRIV_BIT = 4;

    // Element ids and the vendor OUI/type pattern.
    localparam logic [7:0] ID_SSID    = 8'd0;
    localparam logic [7:0] ID_CHANNEL = 8'd3;
    localparam logic [7:0] ID_RSN     = 8'd48;
    localparam logic [7:0] ID_VENDOR  = 8'd221;
    localparam logic [7:0] OUI_0      = 8'h00;
    localparam logic [7:0] OUI_1      = 8'h50;
    localparam logic [7:0] OUI_2      = 8'hF2;
    localparam logic [7:0] OUI_TYPE   = 8'h01;
    localparam logic [7:0] VENDOR_MIN = 8'd4;

    // SSID banks: two held by the parser, one per summary queue entry.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int NBANK  = QDEPTH + 2;
    localparam int BANK_W = $clog2(NBANK);

    // Output buffer of the emitter.
    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = $clog2(OB_DEPTH);
    localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_SSID    = 1'b1;

    typedef enum logic [1:0] {
        SEC_OPEN = 2'd0,
        SEC_WEP  = 2'd1,
        SEC_WPA  = 2'd2,
        SEC_WPA2 = 2'd3
    } t_sec;

    typedef enum logic [1:0] {
        PH_ID  = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic        frame_ok;
        logic [15:0] beacon_interval;
        logic [7:0]  channel_number;
        logic [1:0]  security_kind;
        logic        ssid_present;
        logic [5:0]  ssid_length;
        logic [7:0]  ssid_byte;
        logic        last_of_run;
    } t_out_item;

    // One finished frame as handed from the parser to the emitter.
    typedef struct packed {
        logic              frame_ok;
        logic [15:0]       interval;
        logic [7:0]        channel;
        t_sec              sec;
        logic              ssid_valid;
        logic [5:0]        slen;
        logic [BANK_W-1:0] bank;
    } t_summary;

    typedef struct packed {
        logic             full;
        logic [NBANK-1:0] busy;
    } t_qstat;

    // Address bits of one SSID bank.
    function automatic int ssid_aw(input int ssid_max);
        return (ssid_max > 1) ? $clog2(ssid_max) : 1;
    endfunction

endpackage

[rtl/bep_stream_if.sv]
// Valid/ready stream interface used on both channels of the beacon element parser.
// The payload type is a parameter; the types come from bep_pkg.
interface bep_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/bep_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bep_front.sv]
// Byte parser: walks the fixed header and the elements, stages SSID bytes in the RAM.
// Depends on bep_pkg and bep_stream_if; pushes one summary per frame into bep_queue.
module bep_front #(
    parameter int SSID_MAX = bep_pkg::SSID_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bep_stream_if.sink               i_in,
    input  bep_pkg::t_qstat          i_qstat,
    output logic                     o_push,
    output bep_pkg::t_summary        o_rec,
    output logic                     o_we,
    output logic [bep_pkg::BANK_W+bep_pkg::ssid_aw(SSID_MAX)-1:0] o_waddr,
    output logic [7:0]               o_wdata
);
    localparam int AW  = bep_pkg::ssid_aw(SSID_MAX);
    localparam int LBW = bep_pkg::BANK_W;
    localparam logic [7:0] SSID_MAX_B = 8'(SSID_MAX);

    logic [bep_pkg::OFF_W-1:0] r_off, n_off;
    logic [15:0]               r_interval, n_interval;
    logic                      r_priv, n_priv;
    bep_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                r_id, n_id;
    logic [7:0]                r_len, n_len;
    logic [7:0]                r_pos, n_pos;
    logic [7:0]                r_pending, n_pending;
    logic                      r_oui, n_oui;
    logic [7:0]                r_channel, n_channel;
    bep_pkg::t_sec             r_sec, n_sec;
    logic                      r_seen, n_seen;
    logic [5:0]                r_slen, n_slen;
    logic                      r_svalid, n_svalid;
    logic [LBW-1:0]            r_cbank, n_cbank;
    logic [LBW-1:0]            r_sbank, n_sbank;

    logic           w_accept;
    logic           w_end;
    logic [7:0]     w_b;
    logic           w_body;
    logic           w_is_len;
    logic           w_is_val;
    logic           w_is_id;
    logic           w_val_last;
    logic           w_fin;
    logic [7:0]     w_fin_len;
    logic [bep_pkg::NBANK-1:0] w_mask;
    logic [LBW-1:0] w_free;

    assign i_in.ready = !i_qstat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.data.data_byte;
    assign w_end      = i_in.data.frame_end;
    assign w_body     = (r_off == bep_pkg::OFF_BODY);
    assign w_val_last = ({1'b0, r_pos} + 9'd1) >= {1'b0, r_len};

    // Element walk state.
    always_comb begin
        n_phase = r_phase;
        if (w_accept && w_body) begin
            unique case (r_phase)
                bep_pkg::PH_LEN: n_phase = (w_b == 8'd0) ? bep_pkg::PH_ID : bep_pkg::PH_VAL;
                bep_pkg::PH_VAL: n_phase = w_val_last ? bep_pkg::PH_ID : bep_pkg::PH_VAL;
                default:         n_phase = bep_pkg::PH_LEN;
            endcase
        end
        if (w_accept && w_end) begin
            n_phase = bep_pkg::PH_ID;
        end
    end

    // Phase decode.
    always_comb begin
        w_is_len = 1'b0;
        w_is_val = 1'b0;
        w_is_id  = 1'b0;
        if (w_accept && w_body) begin
            unique case (r_phase)
                bep_pkg::PH_LEN: w_is_len = 1'b1;
                bep_pkg::PH_VAL: w_is_val = 1'b1;
                default:         w_is_id  = 1'b1;
            endcase
        end
    end

    // Lowest bank held neither by the queue nor by the staging area.
    always_comb begin
        w_mask          = i_qstat.busy;
        w_mask[r_sbank] = 1'b1;
        w_free          = '0;
        for (int i = bep_pkg::NBANK - 1; i >= 0; i--) begin
            if (!w_mask[i]) begin
                w_free = LBW'(i);
            end
        end
    end

    assign w_fin     = (w_is_len && (w_b == 8'd0)) || (w_is_val && w_val_last);
    assign w_fin_len = w_is_len ? w_b : r_len;

    always_comb begin
        n_off      = r_off;
        n_interval = r_interval;
        n_priv     = r_priv;
        n_id       = r_id;
        n_len      = r_len;
        n_pos      = r_pos;
        n_pending  = r_pending;
        n_oui      = r_oui;
        n_channel  = r_channel;
        n_sec      = r_sec;
        n_seen     = r_seen;
        n_slen     = r_slen;
        n_svalid   = r_svalid;
        n_cbank    = r_cbank;
        n_sbank    = r_sbank;
        o_push     = 1'b0;
        o_rec      = '0;

        if (w_accept) begin
            if (r_off == bep_pkg::OFF_INT_LO) begin
                n_interval[7:0] = w_b;
            end else if (r_off == bep_pkg::OFF_INT_HI) begin
                n_interval[15:8] = w_b;
            end else if (r_off == bep_pkg::OFF_CAP_LO) begin
                n_priv = w_b[bep_pkg::PRIV_BIT];
            end
            if (!w_body) begin
                n_off = r_off + 1'b1;
            end
        end

        if (w_is_id) begin
            n_id = w_b;
        end
        if (w_is_len) begin
            n_len = w_b;
            n_pos = 8'd0;
            n_oui = 1'b1;
        end
        if (w_is_val) begin
            if (r_pos == 8'd0) begin
                n_pending = w_b;
                if (w_b != bep_pkg::OUI_0) n_oui = 1'b0;
            end
            if ((r_pos == 8'd1) && (w_b != bep_pkg::OUI_1)) n_oui = 1'b0;
            if ((r_pos == 8'd2) && (w_b != bep_pkg::OUI_2)) n_oui = 1'b0;
            if ((r_pos == 8'd3) && (w_b != bep_pkg::OUI_TYPE)) n_oui = 1'b0;
            if (!w_val_last) begin
                n_pos = r_pos + 8'd1;
            end
        end

        // A completed SSID commits by making the staging bank the committed one.
        if (w_fin) begin
            if ((r_id == bep_pkg::ID_SSID) && (w_fin_len != 8'd0)
                    && (w_fin_len <= SSID_MAX_B)) begin
                n_cbank  = r_sbank;
                n_sbank  = w_free;
                n_slen   = w_fin_len[5:0];
                n_svalid = 1'b1;
            end else if ((r_id == bep_pkg::ID_CHANNEL) && (w_fin_len != 8'd0)) begin
                n_channel = n_pending;
            end else if (r_id == bep_pkg::ID_RSN) begin
                n_sec  = bep_pkg::SEC_WPA2;
                n_seen = 1'b1;
            end else if ((r_id == bep_pkg::ID_VENDOR) && (w_fin_len >= bep_pkg::VENDOR_MIN)
                    && n_oui) begin
                if (r_sec < bep_pkg::SEC_WPA) begin
                    n_sec = bep_pkg::SEC_WPA;
                end
                n_seen = 1'b1;
            end
        end

        if (w_accept && w_end) begin
            o_push = 1'b1;
            if (r_off >= bep_pkg::OFF_MIN_OK) begin
                o_rec.frame_ok   = 1'b1;
                o_rec.interval   = n_interval;
                o_rec.channel    = n_channel;
                o_rec.sec        = (!n_seen && n_priv) ? bep_pkg::SEC_WEP : n_sec;
                o_rec.ssid_valid = n_svalid;
                o_rec.slen       = n_svalid ? n_slen : 6'd0;
                o_rec.bank       = n_cbank;
            end
            n_off      = '0;
            n_interval = '0;
            n_priv     = 1'b0;
            n_id       = '0;
            n_len      = '0;
            n_pos      = '0;
            n_pending  = '0;
            n_oui      = 1'b0;
            n_channel  = '0;
            n_sec      = bep_pkg::SEC_OPEN;
            n_seen     = 1'b0;
            n_slen     = '0;
            n_svalid   = 1'b0;
        end
    end

    assign o_we    = w_is_val && (r_pos < SSID_MAX_B);
    assign o_waddr = {r_sbank, r_pos[AW-1:0]};
    assign o_wdata = w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= '0;
            r_interval <= '0;
            r_priv     <= 1'b0;
            r_phase    <= bep_pkg::PH_ID;
            r_id       <= '0;
            r_len      <= '0;
            r_pos      <= '0;
            r_pending  <= '0;
            r_oui      <= 1'b0;
            r_channel  <= '0;
            r_sec      <= bep_pkg::SEC_OPEN;
            r_seen     <= 1'b0;
            r_slen     <= '0;
            r_svalid   <= 1'b0;
            r_cbank    <= '0;
            r_sbank    <= '0;
        end else begin
            r_off      <= n_off;
            r_interval <= n_interval;
            r_priv     <= n_priv;
            r_phase    <= n_phase;
            r_id       <= n_id;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_pending  <= n_pending;
            r_oui      <= n_oui;
            r_channel  <= n_channel;
            r_sec      <= n_sec;
            r_seen     <= n_seen;
            r_slen     <= n_slen;
            r_svalid   <= n_svalid;
            r_cbank    <= n_cbank;
            r_sbank    <= n_sbank;
        end
    end
endmodule

[rtl/bep_queue.sv]
// Short queue of frame summaries between the parser and the emitter.
// Depends on bep_pkg; reports fullness and the SSID banks its entries hold.
module bep_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bep_pkg::t_summary i_rec,
    input  logic              i_pop,
    output bep_pkg::t_qstat   o_qstat,
    output logic              o_head_valid,
    output bep_pkg::t_summary o_head
);
    localparam int LQ = bep_pkg::QPTR_W;
    localparam int LC = bep_pkg::QCNT_W;

    bep_pkg::t_summary r_ent [bep_pkg::QDEPTH];
    logic [LQ-1:0]     r_wp, r_rp;
    logic [LC-1:0]     r_cnt;
    logic [LQ-1:0]     w_rel [bep_pkg::QDEPTH];

    // Only an entry with a committed SSID holds its bank; the bank field of any
    // other entry is ignored here.
    always_comb begin
        o_qstat.busy = '0;
        for (int i = 0; i < bep_pkg::QDEPTH; i++) begin
            w_rel[i] = LQ'(i) - r_rp;
            if ((LC'(w_rel[i]) < r_cnt) && r_ent[i].ssid_valid) begin
                o_qstat.busy[r_ent[i].bank] = 1'b1;
            end
        end
        o_qstat.full = (r_cnt == LC'(bep_pkg::QDEPTH));
    end

    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + LC'(i_push) - LC'(i_pop);
        end
    end
endmodule

[rtl/bep_back.sv]
// Result emitter: turns one summary into the summary item and the SSID byte items.
// Depends on bep_pkg and bep_stream_if; reads SSID bytes from bep_ram.
module bep_back #(
    parameter int SSID_MAX = bep_pkg::SSID_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  bep_pkg::t_summary i_head,
    output logic              o_pop,
    output logic [bep_pkg::BANK_W+bep_pkg::ssid_aw(SSID_MAX)-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    bep_stream_if.source      o_out
);
    localparam int AW = bep_pkg::ssid_aw(SSID_MAX);
    localparam int LP = bep_pkg::OB_PTR_W;
    localparam int LC = bep_pkg::OB_CNT_W;

    logic [5:0]         r_k;
    logic [5:0]         w_km1;
    logic               r_infl;
    bep_pkg::t_out_item r_desc;
    bep_pkg::t_out_item w_desc;
    bep_pkg::t_out_item w_arrive;
    bep_pkg::t_out_item r_buf [bep_pkg::OB_DEPTH];
    logic [LP-1:0]      r_wp, r_rp;
    logic [LC-1:0]      r_cnt;
    logic [LC-1:0]      w_occ;
    logic               w_opop;
    logic               w_issue;
    logic               w_last;

    assign w_opop  = o_out.valid && o_out.ready;
    assign w_occ   = r_cnt + LC'(r_infl);
    // Buffered plus in-flight items never exceed the buffer depth.
    assign w_issue = i_head_valid && ((w_occ < LC'(bep_pkg::OB_DEPTH)) || w_opop);
    assign w_last  = (r_k == i_head.slen);
    assign o_pop   = w_issue && w_last;
    assign w_km1   = r_k - 6'd1;
    assign o_raddr = {i_head.bank, w_km1[AW-1:0]};

    always_comb begin
        w_desc.item_kind       = (r_k != 6'd0) ? bep_pkg::KIND_SSID : bep_pkg::KIND_SUMMARY;
        w_desc.frame_ok        = i_head.frame_ok;
        w_desc.beacon_interval = i_head.interval;
        w_desc.channel_number  = i_head.channel;
        w_desc.security_kind   = i_head.sec;
        w_desc.ssid_present    = i_head.ssid_valid;
        w_desc.ssid_length     = i_head.slen;
        w_desc.ssid_byte       = 8'd0;
        w_desc.last_of_run     = w_last;
    end

    always_comb begin
        w_arrive = r_desc;
        if (r_desc.item_kind == bep_pkg::KIND_SSID) begin
            w_arrive.ssid_byte = i_rdata;
        end
    end

    assign o_out.valid = (r_cnt != '0);
    assign o_out.data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_desc <= w_desc;
        end
        if (r_infl) begin
            r_buf[r_wp] <= w_arrive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_infl <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_infl <= w_issue;
            if (w_issue) begin
                r_k <= w_last ? 6'd0 : r_k + 6'd1;
            end
            if (r_infl) r_wp <= r_wp + 1'b1;
            if (w_opop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + LC'(r_infl) - LC'(w_opop);
        end
    end
endmodule

[rtl/beacon_element_parser.sv]
// Beacon frame element parser. Frame bytes enter on i_in one per cycle, starting at the
// frame control byte, with frame_end set on the last byte; the input takes one byte every
// cycle as long as the two-entry summary queue has room, and it drops ready only while two
// finished frames still wait to be emitted. For each frame o_out delivers one summary
// transaction followed by one transaction per committed SSID byte (1 + ssid_length in all),
// at one per cycle while the sink is ready; the registered SSID RAM read is hidden by a
// two-entry output buffer, and a summary passes the queue and the descriptor register
// before it enters that buffer. SSID bytes are staged in a RAM of four banks, and a complete
// SSID element is committed by switching banks, so no copy takes place. The RAM needs no
// clearing after reset: only committed bytes are ever emitted.
// Depends on bep_pkg, bep_stream_if, bep_ram, bep_front, bep_queue and bep_back.
`include "beacon_element_parser_macros.svh"

module beacon_element_parser #(
    parameter int SSID_MAX = bep_pkg::SSID_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bep_stream_if.sink   i_in,
    bep_stream_if.source o_out
);
    // Each bank holds one SSID; the address is the bank above the byte index.
    localparam int AW     = bep_pkg::ssid_aw(SSID_MAX);
    localparam int RAM_AW = bep_pkg::BANK_W + AW;
    localparam int DEPTH  = bep_pkg::NBANK * (2 ** AW);

    bep_pkg::t_qstat   w_qstat;
    bep_pkg::t_summary w_rec;
    bep_pkg::t_summary w_head;
    logic              w_push;
    logic              w_pop;
    logic              w_head_valid;
    logic              w_we;
    logic [RAM_AW-1:0] w_waddr;
    logic [RAM_AW-1:0] w_raddr;
    logic [7:0]        w_wdata;
    logic [7:0]        w_rdata;

    // The parser follows the fixed header and the elements byte by byte.
    bep_front #(
        .SSID_MAX (SSID_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_rec   (w_rec),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata)
    );

    // Finished frames wait here; each entry with a committed SSID keeps its bank reserved.
    bep_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_rec        (w_rec),
        .i_pop        (w_pop),
        .o_qstat      (w_qstat),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    bep_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ssid_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The emitter releases a queue entry when it issues the last item of the frame.
    bep_back #(
        .SSID_MAX (SSID_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata),
        .o_out        (o_out)
    );

    // A frame summary is never pushed into a full queue.
    `BEP_ASSERT_NEVER(a_push_full, w_push && w_qstat.full, "summary pushed into full queue")

    // Staging writes never land in a bank that a queued frame still owns.
    `BEP_ASSERT_NEVER(a_bank_clash, w_we && w_qstat.busy[w_waddr[RAM_AW-1:AW]],
        "SSID staging write into a bank held by the queue")

    // The emitter only releases an entry that exists.
    `BEP_ASSERT_IMPLIES(a_pop_valid, w_pop, w_head_valid, "queue pop without an entry")

    // SSID byte results belong to a frame with a committed, nonempty SSID.
    `BEP_ASSERT_IMPLIES(a_ssid_item, o_out.valid && (o_out.data.item_kind == bep_pkg::KIND_SSID),
        o_out.data.ssid_present && (o_out.data.ssid_length != 6'd0),
        "SSID byte result without a committed SSID")
endmodule
